[design/hbcs_pkg.sv]
// ----------------------------------------------------------------------------
// hbcs_pkg
// Shared types, character codes and helpers of the hex bank command server.
// ----------------------------------------------------------------------------
package hbcs_pkg;

  // field and register widths fixed by the command format
  localparam int ByteW    = 8;
  localparam int DigitW   = 4;
  localparam int SizeW    = 5;
  localparam int TimeoutW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int NibCntW  = 6;

  // command queue depth between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BANK_COUNT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BANK_SIZE     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // configuration reset values
  localparam logic [DigitW-1:0]   RST_BANK_COUNT = 4'd10;
  localparam logic [SizeW-1:0]    RST_BANK_SIZE  = 5'd16;
  localparam logic [TimeoutW-1:0] RST_TIMEOUT    = 16'd1000;

  // ascii codes
  localparam logic [ByteW-1:0] CHAR_G  = 8'h47;
  localparam logic [ByteW-1:0] CHAR_S  = 8'h53;
  localparam logic [ByteW-1:0] CHAR_C  = 8'h43;
  localparam logic [ByteW-1:0] CHAR_NL = 8'h0a;
  localparam logic [ByteW-1:0] CHAR_0  = 8'h30;
  localparam logic [ByteW-1:0] CHAR_9  = 8'h39;
  localparam logic [ByteW-1:0] CHAR_UA = 8'h41;
  localparam logic [ByteW-1:0] CHAR_UZ = 8'h5a;
  localparam logic [ByteW-1:0] CHAR_LA = 8'h61;
  localparam logic [ByteW-1:0] CHAR_LF = 8'h66;
  localparam logic [ByteW-1:0] CASE_OFFSET = 8'h20;
  localparam logic [3:0]       NIB_MASK = 4'hf;

  // parser phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BANK,
    PH_NL,
    PH_DATA
  } phase_t;

  // pending command
  typedef enum logic [1:0] {
    CMD_G,
    CMD_S,
    CMD_C
  } cmd_t;

  // operations for the back end
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLEAR,
    OP_DUMP
  } op_t;

  // back end states
  typedef enum logic [2:0] {
    B_IDLE,
    B_CLEAR,
    B_DUMP_HI,
    B_DUMP_LO,
    B_DUMP_NL
  } bstate_t;

  // one queued operation; clear and dump carry the byte count in data
  typedef struct packed {
    op_t               op;
    logic [DigitW-1:0] bank;
    logic [SizeW-1:0]  idx;
    logic [ByteW-1:0]  data;
  } q_entry_t;

  // lowercase hex character of a nibble
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] v);
    logic [ByteW-1:0] ext;
    ext = {4'd0, v & NIB_MASK};
    if (v >= 4'd10) begin
      return CHAR_LA + ext - 8'd10;
    end
    return CHAR_0 + ext;
  endfunction

endpackage

[design/hbcs_ram.sv]
// ----------------------------------------------------------------------------
// hbcs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hbcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 160,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AddrW-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/hbcs_front.sv]
// ----------------------------------------------------------------------------
// hbcs_front
// Command parser: takes bytes and ticks, keeps configuration, tracks the
// timeout and turns commands and hex digits into queued operations.
// ----------------------------------------------------------------------------
module hbcs_front #(
  parameter int NUM_BANKS  = 10,
  parameter int BANK_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          in_kind,
  input  logic [hbcs_pkg::ByteW-1:0]    in_byte,
  input  logic                          cfg_we,
  input  logic [hbcs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hbcs_pkg::CfgDataW-1:0] cfg_wdata,
  output logic                          push,
  output hbcs_pkg::q_entry_t            push_entry
);

  import hbcs_pkg::*;

  phase_t              phase_r, phase_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [DigitW-1:0]   bank_r, bank_nxt;
  logic [NibCntW-1:0]  nib_r, nib_nxt;
  logic [TimeoutW-1:0] wait_r, wait_nxt;
  logic [3:0]          hi_r, hi_nxt;

  logic [DigitW-1:0]   bank_count_r;
  logic [SizeW-1:0]    bank_size_r;
  logic [TimeoutW-1:0] timeout_r;

  logic [DigitW-1:0] eff_count;
  logic [SizeW-1:0]  eff_size;
  logic [ByteW-1:0]  digit_off;
  logic [ByteW-1:0]  folded;
  logic [ByteW-1:0]  fold_dig;
  logic [ByteW-1:0]  fold_alpha;
  logic [NibCntW:0]  nib_inc;

  // effective bank count and size
  assign eff_count = (bank_count_r < DigitW'(NUM_BANKS)) ? bank_count_r : DigitW'(NUM_BANKS);
  assign eff_size  = (bank_size_r < SizeW'(BANK_BYTES)) ? bank_size_r : SizeW'(BANK_BYTES);

  // character helpers
  assign digit_off  = in_byte - CHAR_0;
  assign folded     = (in_byte inside {[CHAR_UA:CHAR_UZ]}) ? in_byte + CASE_OFFSET : in_byte;
  assign fold_dig   = folded - CHAR_0;
  assign fold_alpha = folded - CHAR_LA;
  assign nib_inc    = {1'b0, nib_r} + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r <= RST_BANK_COUNT;
      bank_size_r  <= RST_BANK_SIZE;
      timeout_r    <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BANK_COUNT:    bank_count_r <= cfg_wdata[DigitW-1:0];
        CFG_BANK_SIZE:     bank_size_r  <= cfg_wdata[SizeW-1:0];
        CFG_TIMEOUT_TICKS: timeout_r    <= cfg_wdata[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= CMD_G;
      bank_r  <= '0;
      nib_r   <= '0;
      wait_r  <= '0;
      hi_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      bank_r  <= bank_nxt;
      nib_r   <= nib_nxt;
      wait_r  <= wait_nxt;
      hi_r    <= hi_nxt;
    end
  end

  // next state and queued operation
  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    bank_nxt   = bank_r;
    nib_nxt    = nib_r;
    wait_nxt   = wait_r;
    hi_nxt     = hi_r;
    push       = 1'b0;
    push_entry = '{op: OP_WRITE, bank: bank_r, idx: '0, data: '0};

    if (in_fire) begin
      if (in_kind) begin
        // time tick: count or give up
        if (phase_r != PH_IDLE) begin
          if (wait_r >= timeout_r) begin
            phase_nxt = PH_IDLE;
            wait_nxt  = '0;
          end else begin
            wait_nxt = wait_r + 1'b1;
          end
        end
      end else begin
        wait_nxt = '0;
        case (phase_r)
          PH_IDLE: begin
            if (in_byte == CHAR_G) begin
              cmd_nxt   = CMD_G;
              phase_nxt = PH_BANK;
            end else if (in_byte == CHAR_S) begin
              cmd_nxt   = CMD_S;
              phase_nxt = PH_BANK;
            end else if (in_byte == CHAR_C) begin
              cmd_nxt   = CMD_C;
              phase_nxt = PH_BANK;
            end
          end
          PH_BANK: begin
            if ((in_byte inside {[CHAR_0:CHAR_9]}) && (digit_off < {4'd0, eff_count})) begin
              bank_nxt  = digit_off[DigitW-1:0];
              phase_nxt = PH_NL;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_NL: begin
            phase_nxt = PH_IDLE;
            if (in_byte == CHAR_NL) begin
              push_entry.data = {3'd0, eff_size};
              if (cmd_r == CMD_G) begin
                push_entry.op = OP_DUMP;
                push          = 1'b1;
              end else if (eff_size != '0) begin
                push_entry.op = OP_CLEAR;
                push          = 1'b1;
                if (cmd_r == CMD_S) begin
                  nib_nxt   = '0;
                  phase_nxt = PH_DATA;
                end
              end
            end
          end
          PH_DATA: begin
            if (in_byte == CHAR_NL) begin
              phase_nxt = PH_IDLE;
            end else if ((folded inside {[CHAR_0:CHAR_9]}) ||
                         (folded inside {[CHAR_LA:CHAR_LF]})) begin
              push           = 1'b1;
              push_entry.op  = OP_WRITE;
              push_entry.idx = nib_r[NibCntW-1:1];
              if (nib_r[0] == 1'b0) begin
                if (folded inside {[CHAR_0:CHAR_9]}) begin
                  hi_nxt          = fold_dig[3:0];
                  push_entry.data = {fold_dig[3:0], 4'd0};
                end else begin
                  hi_nxt          = fold_alpha[3:0] + 4'd10;
                  push_entry.data = {fold_alpha[3:0] + 4'd10, 4'd0};
                end
              end else begin
                if (folded inside {[CHAR_0:CHAR_9]}) begin
                  push_entry.data = {hi_r, fold_dig[3:0]};
                end else begin
                  push_entry.data = {hi_r, fold_alpha[3:0] + 4'd10};
                end
              end
              nib_nxt = nib_inc[NibCntW-1:0];
              if (nib_inc >= {1'b0, eff_size, 1'b0}) begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

endmodule

[design/hbcs_queue.sv]
// ----------------------------------------------------------------------------
// hbcs_queue
// Short operation queue between parser and executor.
// ----------------------------------------------------------------------------
module hbcs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hbcs_pkg::q_entry_t push_entry,
  input  logic               pop,
  output hbcs_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);

  import hbcs_pkg::*;

  q_entry_t         q_mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCntW'(QDepth));
  assign head  = q_mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
                                  count_r <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

[design/hbcs_back.sv]
// ----------------------------------------------------------------------------
// hbcs_back
// Executor: pops operations, writes and clears bank memory and streams
// bank dumps as hex characters through an output register.
// ----------------------------------------------------------------------------
module hbcs_back #(
  parameter int NUM_BANKS  = 10,
  parameter int BANK_BYTES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hbcs_pkg::q_entry_t         head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hbcs_pkg::ByteW-1:0] out_tdata,   // out_byte
  output logic                       out_tlast    // last
);

  import hbcs_pkg::*;

  localparam int Depth = NUM_BANKS * BANK_BYTES;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CalcW = AW + SizeW;

  bstate_t           state_r, state_nxt;
  logic [DigitW-1:0] bank_r, bank_nxt;
  logic [SizeW-1:0]  cnt_r, cnt_nxt;
  logic [SizeW-1:0]  size_r, size_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [ByteW-1:0]  odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  logic              slot_free;

  logic [DigitW-1:0] bank_sel;
  logic [SizeW-1:0]  idx_sel;
  logic [CalcW-1:0]  addr_full;
  logic              ram_we;
  logic              ram_re;
  logic [ByteW-1:0]  ram_wdata;
  logic [ByteW-1:0]  ram_rdata;
  logic [SizeW:0]    cnt_inc;

  assign slot_free = !ovalid_r || out_tready;
  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign addr_full = CalcW'(bank_sel) * CalcW'(BANK_BYTES) + CalcW'(idx_sel);

  hbcs_ram #(
    .Width (ByteW),
    .Depth (Depth),
    .AddrW (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr_full[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      bank_r   <= '0;
      cnt_r    <= '0;
      size_r   <= '0;
      ovalid_r <= 1'b0;
      olast_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bank_r   <= bank_nxt;
      cnt_r    <= cnt_nxt;
      size_r   <= size_nxt;
      ovalid_r <= ovalid_nxt;
      olast_r  <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    pop        = 1'b0;
    bank_sel   = bank_r;
    idx_sel    = cnt_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = '0;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;

    case (state_r)
      B_IDLE: begin
        bank_sel = head.bank;
        idx_sel  = head.idx;
        if (!empty) begin
          pop      = 1'b1;
          bank_nxt = head.bank;
          size_nxt = head.data[SizeW-1:0];
          cnt_nxt  = '0;
          case (head.op)
            OP_WRITE: begin
              ram_we    = 1'b1;
              ram_wdata = head.data;
            end
            OP_CLEAR: state_nxt = B_CLEAR;
            OP_DUMP: begin
              idx_sel = '0;
              if (head.data[SizeW-1:0] == '0) begin
                state_nxt = B_DUMP_NL;
              end else begin
                ram_re    = 1'b1;
                state_nxt = B_DUMP_HI;
              end
            end
            default: ;
          endcase
        end
      end
      B_CLEAR: begin
        // one byte zeroed per cycle
        ram_we  = 1'b1;
        cnt_nxt = cnt_inc[SizeW-1:0];
        if (cnt_inc == {1'b0, size_r}) begin
          state_nxt = B_IDLE;
        end
      end
      B_DUMP_HI: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = hex_char(ram_rdata[7:4]);
          olast_nxt  = 1'b0;
          state_nxt  = B_DUMP_LO;
        end
      end
      B_DUMP_LO: begin
        // low digit goes out while the next byte, if any, is read
        idx_sel = cnt_inc[SizeW-1:0];
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = hex_char(ram_rdata[3:0]);
          olast_nxt  = 1'b0;
          if (cnt_inc == {1'b0, size_r}) begin
            state_nxt = B_DUMP_NL;
          end else begin
            ram_re    = 1'b1;
            cnt_nxt   = cnt_inc[SizeW-1:0];
            state_nxt = B_DUMP_HI;
          end
        end
      end
      B_DUMP_NL: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = CHAR_NL;
          olast_nxt  = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  a_dump_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DUMP_HI || state_r == B_DUMP_LO || state_r == B_DUMP_NL) |-> !ram_we)
    else $error("memory written during dump");
  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == CHAR_NL))
    else $error("last flag on a non-newline character");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE && !empty))
    else $error("operation popped while busy");

endmodule

[design/hex_bank_command_server.sv]
// A byte or tick is parsed in the cycle it is accepted; after its newline a
// dump's first character passes the queue, RAM read and output registers.
// Throughput: one input word per cycle while the 4-entry operation queue has
// room; a dump sends 2*size+1 words, one per cycle unless out_tready is low.
// Reset: synchronous active-low rst_n clears parser, queue, executor and
// configuration (10 banks, 16 bytes, 1000 ticks); bank memory keeps its data.
// ----------------------------------------------------------------------------
// hex_bank_command_server
// Serial command server over banks of bytes: G dumps a bank as hex, C
// zeroes it, S zeroes it and loads hex digits into it.
// ----------------------------------------------------------------------------
module hex_bank_command_server #(
  parameter int NUM_BANKS  = 10,
  parameter int BANK_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hbcs_pkg::ByteW-1:0]    in_tdata,   // data_byte
  input  logic                          in_tuser,   // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hbcs_pkg::ByteW-1:0]    out_tdata,  // out_byte
  output logic                          out_tlast,  // last
  input  logic                          cfg_we,
  input  logic [hbcs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hbcs_pkg::CfgDataW-1:0] cfg_wdata
);

  import hbcs_pkg::*;

  logic     in_fire;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;
  q_entry_t push_entry;
  q_entry_t head;

  // words are taken whenever the queue can hold one more operation
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  hbcs_front #(
    .NUM_BANKS  (NUM_BANKS),
    .BANK_BYTES (BANK_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_kind    (in_tuser),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .push_entry (push_entry)
  );

  hbcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  hbcs_back #(
    .NUM_BANKS  (NUM_BANKS),
    .BANK_BYTES (BANK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/sv/hex_bank_command_server_tb.sv]
// ----------------------------------------------------------------------------
// hex_bank_command_server_tb
// Self-checking bench for the hex bank command server. Serial bytes and
// ticks stream in with random gaps; a bit-level predictor of the parser and
// bank memory builds the expected dump characters, which a monitor compares
// in order against the output stream under random back-pressure.
// ----------------------------------------------------------------------------
module hex_bank_command_server_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbcs_pkg::*;

  localparam int NumBanks  = 10;
  localparam int BankBytes = 16;
  localparam int MemDepth  = NumBanks * BankBytes;
  localparam logic [ByteW-1:0] CHAR_X = 8'h78;

  // one word toward the block and one dump character back
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
  } link_word_t;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
  } dump_char_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ByteW-1:0]    out_tdata;
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // stimulus and expectation stores
  link_word_t link_words[$];
  dump_char_t dump_chars[$];
  int         fed_count = 0;
  int         results_seen = 0;
  int         errors = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;

  // predictor copy of the registers
  logic [DigitW-1:0]   cfg_banks = RST_BANK_COUNT;
  logic [SizeW-1:0]    cfg_bytes = RST_BANK_SIZE;
  logic [TimeoutW-1:0] tmo_ticks = RST_TIMEOUT;

  // predictor copy of the parser and memory
  phase_t              phase = PH_IDLE;
  cmd_t                cmd = CMD_G;
  logic [DigitW-1:0]   sel_bank = '0;
  logic [NibCntW-1:0]  nib = '0;
  logic [TimeoutW-1:0] ticks_waited = '0;
  logic [ByteW-1:0]    bank_image [MemDepth];
  bit                  mem_known [MemDepth];
  string               hex_digits = "0123456789abcdef";

  hex_bank_command_server #(
    .NUM_BANKS (NumBanks),
    .BANK_BYTES(BankBytes)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int eff_banks();
    return (int'(cfg_banks) < NumBanks) ? int'(cfg_banks) : NumBanks;
  endfunction

  function automatic int eff_bytes();
    return (int'(cfg_bytes) < BankBytes) ? int'(cfg_bytes) : BankBytes;
  endfunction

  function automatic void go_idle();
    phase = PH_IDLE;
    ticks_waited = '0;
  endfunction

  // every byte a dump of the selected bank would read has been written
  function automatic bit bank_ready();
    for (int i = 0; i < eff_bytes(); i++) begin
      if (!mem_known[int'(sel_bank) * BankBytes + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the parser by one word, queue any dump characters;
  // returns 1 when the word was not simply ignored
  function automatic bit parse_link_word(input logic kind, input logic [ByteW-1:0] c);
    int         size;
    int         base;
    int         addr;
    logic [ByteW-1:0] ch;
    logic [ByteW-1:0] b;
    logic [3:0] nv;
    bit         hex_ok;
    bit         busy;
    dump_char_t oc;
    size = eff_bytes();
    base = int'(sel_bank) * BankBytes;
    busy = (phase != PH_IDLE);
    ch = c;
    hex_ok = 1'b0;
    nv = '0;
    // ticks only count while a command is open
    if (kind) begin
      if (busy) begin
        if (ticks_waited >= tmo_ticks) go_idle();
        else ticks_waited = ticks_waited + 1'b1;
      end
      return busy;
    end
    ticks_waited = '0;
    case (phase)
      PH_IDLE: begin
        if (ch == CHAR_G || ch == CHAR_S || ch == CHAR_C) begin
          cmd = (ch == CHAR_G) ? CMD_G : ((ch == CHAR_S) ? CMD_S : CMD_C);
          phase = PH_BANK;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_BANK: begin
        if (ch >= CHAR_0 && ch <= CHAR_9 && int'(ch - CHAR_0) < eff_banks()) begin
          sel_bank = 4'(ch - CHAR_0);
          phase = PH_NL;
        end else begin
          go_idle();
        end
      end
      PH_NL: begin
        if (ch != CHAR_NL) begin
          go_idle();
        end else if (cmd == CMD_G) begin
          // dump high nibble first, then the closing newline
          oc.last = 1'b0;
          for (int i = 0; i < size; i++) begin
            b = bank_image[base + i];
            oc.ch = hex_digits[b[7:4]];
            dump_chars.push_back(oc);
            oc.ch = hex_digits[b[3:0]];
            dump_chars.push_back(oc);
          end
          oc.ch = CHAR_NL;
          oc.last = 1'b1;
          dump_chars.push_back(oc);
          go_idle();
        end else begin
          for (int i = 0; i < size; i++) begin
            bank_image[base + i] = '0;
            mem_known[base + i] = 1'b1;
          end
          if (cmd == CMD_S && size > 0) begin
            nib = '0;
            phase = PH_DATA;
          end else begin
            go_idle();
          end
        end
      end
      default: begin
        if (ch == CHAR_NL) begin
          go_idle();
        end else begin
          if (ch >= CHAR_UA && ch <= CHAR_UZ) ch = ch + CASE_OFFSET;
          if (ch >= CHAR_0 && ch <= CHAR_9) begin
            nv = 4'(ch - CHAR_0);
            hex_ok = 1'b1;
          end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
            nv = 4'(ch - CHAR_LA + 8'd10);
            hex_ok = 1'b1;
          end
          if (hex_ok) begin
            addr = base + int'(nib >> 1);
            if (!nib[0]) bank_image[addr] = {nv, 4'h0};
            else bank_image[addr] = bank_image[addr] | {4'h0, nv};
            nib = nib + 1'b1;
            if (int'(nib) >= 2 * size) go_idle();
          end
        end
      end
    endcase
    return 1'b1;
  endfunction

  // queue one word; a dump of a bank with unwritten bytes is turned
  // into a missing-newline abort
  task automatic offer(input logic kind, input logic [ByteW-1:0] c);
    link_word_t w;
    w.kind = kind;
    w.data = c;
    if (!kind && c == CHAR_NL && phase == PH_NL && cmd == CMD_G && !bank_ready())
      w.data = CHAR_X;
    link_words.push_back(w);
    if (parse_link_word(w.kind, w.data)) fed_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [ByteW-1:0] random_hex_char();
    logic [ByteW-1:0] v;
    v = 8'($urandom_range(15));
    if (v < 8'd10) return CHAR_0 + v;
    return ($urandom_range(1) ? CHAR_UA : CHAR_LA) + v - 8'd10;
  endfunction

  task automatic tick_burst(input int n);
    for (int i = 0; i < n; i++) offer(1'b1, 8'($urandom_range(255)));
  endtask

  // mostly well-formed commands, the rest broken commands, noise and ticks
  task automatic random_phase(input int budget);
    int start;
    int r;
    int n;
    logic [ByteW-1:0] letter;
    start = fed_count;
    while (fed_count - start < budget) begin
      r = $urandom_range(99);
      case ($urandom_range(2))
        0: letter = CHAR_G;
        1: letter = CHAR_S;
        default: letter = CHAR_C;
      endcase
      if (r < 60) begin
        offer(1'b0, letter);
        if ($urandom_range(9) == 0) tick_burst($urandom_range(3, 1));
        offer(1'b0, CHAR_0 + 8'($urandom_range(eff_banks() - 1)));
        if ($urandom_range(9) == 0) tick_burst($urandom_range(3, 1));
        offer(1'b0, CHAR_NL);
        if (letter == CHAR_S) begin
          n = $urandom_range(2 * eff_bytes() + 2);
          for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 80) offer(1'b0, random_hex_char());
            else if (r < 90) offer(1'b0, 8'($urandom_range(255)));
            else tick_burst($urandom_range(3, 1));
          end
          if ($urandom_range(9) < 7) offer(1'b0, CHAR_NL);
        end
      end else if (r < 75) begin
        offer(1'b0, letter);
        if ($urandom_range(1)) begin
          offer(1'b0, 8'($urandom_range(255)));
        end else begin
          offer(1'b0, CHAR_0 + 8'($urandom_range(eff_banks() - 1)));
          offer(1'b0, 8'($urandom_range(255)));
        end
      end else if (r < 90) begin
        offer(1'b0, 8'($urandom_range(255)));
      end else begin
        tick_burst($urandom_range(4, 1));
      end
    end
  endtask

  // wait until every queued word is taken and every character is back
  task automatic settle();
    while (link_words.size() != 0 || in_tvalid || dump_chars.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DigitW-1:0] cnt, input logic [SizeW-1:0] sz,
                            input logic [TimeoutW-1:0] tmo);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BANK_COUNT;
    cfg_wdata <= CfgDataW'(cnt);
    @(posedge clk);
    cfg_index <= CFG_BANK_SIZE;
    cfg_wdata <= CfgDataW'(sz);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_banks = cnt;
    cfg_bytes = sz;
    tmo_ticks = tmo;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("mismatch %0d: %s", results_seen, msg);
  endtask

  // sender: one word at a time with random gaps
  always @(posedge clk) begin : drive_link
    link_word_t w;
    int tx_gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        tx_gap = tx_gap - 1;
      end else if (link_words.size() != 0) begin
        w = link_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.data;
        in_tuser  <= w.kind;
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off during the first dump,
  // while the directed words behind it keep the queue filling up
  always @(posedge clk) begin : drive_ready
    int rx_hold;
    bit long_hold_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
      long_hold_done = 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (!long_hold_done && results_seen >= 1) begin
      out_tready <= 1'b0;
      rx_hold = 400;
      long_hold_done = 1'b1;
    end else if (rx_idle_on && $urandom_range(99) < 25) begin
      out_tready <= 1'b0;
      rx_hold = pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each dump character with the oldest expectation
  always @(posedge clk) begin : check_dump
    dump_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (dump_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
      end else begin
        want = dump_chars.pop_front();
        if (out_tdata !== want.ch)
          report_mismatch($sformatf("byte %h, want %h", out_tdata, want.ch));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle noise, clear and dump, load with folding and skips,
    // bad digit, missing newline
    offer(1'b0, 8'hff);
    offer(1'b1, 8'h00);
    offer(1'b0, 8'h00);
    offer(1'b0, CHAR_C);
    offer(1'b0, "1");
    offer(1'b0, CHAR_NL);
    offer(1'b0, CHAR_G);
    offer(1'b0, "1");
    offer(1'b0, CHAR_NL);
    offer(1'b0, CHAR_S);
    offer(1'b0, "0");
    offer(1'b0, CHAR_NL);
    offer(1'b0, "f");
    offer(1'b0, "F");
    offer(1'b0, "z");
    offer(1'b0, "A");
    offer(1'b0, "9");
    offer(1'b0, CHAR_NL);
    offer(1'b0, CHAR_G);
    offer(1'b0, "0");
    offer(1'b0, CHAR_NL);
    offer(1'b0, CHAR_G);
    offer(1'b0, CHAR_X);
    offer(1'b0, CHAR_C);
    offer(1'b0, "0");
    offer(1'b0, "0");
    settle();

    // all banks, full size, timeout never reached
    write_regs(4'd10, 5'd16, 16'hffff);
    random_phase(25);
    settle();

    // one bank of one byte, any tick in a command aborts; sender never idles
    tx_idle_on = 1'b0;
    write_regs(4'd1, 5'd1, 16'd0);
    random_phase(25);
    settle();

    // mid-range sizes with short timeouts; receiver always ready
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    write_regs(4'($urandom_range(9, 2)), 5'($urandom_range(15, 2)),
               16'($urandom_range(4, 1)));
    random_phase(25);
    settle();

    // random geometry with the default timeout
    rx_idle_on = 1'b1;
    write_regs(4'($urandom_range(10, 1)), 5'($urandom_range(16, 1)), RST_TIMEOUT);
    random_phase(25);
    settle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
design/hbcs_pkg.sv
design/hbcs_ram.sv
design/hbcs_front.sv
design/hbcs_queue.sv
design/hbcs_back.sv
design/hex_bank_command_server.sv
tb/sv/hex_bank_command_server_tb.sv
